// ===== src/ctm_pkg.sv =====
// Package for the clock pulse tempo meter: register map, reset values,
// fixed-point constants and the types shared by the front, back and top level.
// No dependencies.
`default_nettype none

package ctm_pkg;

  localparam int NUM_BITS   = 40;  // 6000000 * Q16 factor fits in 23 + 17 bits
  localparam int CENTI_BITS = 20;
  localparam int SUM_BITS   = 24;
  localparam int GRP_BITS   = 5;
  localparam int CNT_BITS   = 7;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  localparam logic [22:0] CENTI_MINUTE_MS = 23'd6000000;
  localparam logic [CENTI_BITS-1:0] BPM_MAX = 20'd1000000;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LEVEL_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_PULSES_PER_BEAT   = 3'd1;
  localparam logic [2:0] REG_GROUPS_TO_AVERAGE = 3'd2;
  localparam logic [2:0] REG_CORRECTION_Q16    = 3'd3;
  localparam logic [2:0] REG_DIVIDE_RATIO      = 3'd4;

  localparam logic [15:0] RST_LEVEL_THRESHOLD   = 16'd32768;
  localparam logic [6:0]  RST_PULSES_PER_BEAT   = 7'd24;
  localparam logic [4:0]  RST_GROUPS_TO_AVERAGE = 5'd4;
  localparam logic [16:0] RST_CORRECTION_Q16    = 17'd62785;
  localparam logic [6:0]  RST_DIVIDE_RATIO      = 7'd24;

  localparam logic [GRP_BITS-1:0] GROUPS_MAX = 5'd16;

  typedef struct packed {
    logic [15:0] level_threshold;
    logic [6:0]  pulses_per_beat;
    logic [4:0]  groups_to_average;
    logic [16:0] correction_q16;
    logic [6:0]  divide_ratio;
  } ctm_cfg_t;

  // classification handed from the front to the back through the queue
  typedef struct packed {
    logic edge_seen;
    logic divided_tick;
    logic group_done;
  } ctm_flags_t;

  localparam int FLAG_BITS = $bits(ctm_flags_t);

endpackage

`default_nettype wire

// ===== src/ctm_front.sv =====
// Front end: edge detection, pulse grouping, divided tick and span per sample.
// Pushes one classified transaction per accepted sample into the queue.
// Depends on ctm_pkg.
`default_nettype none

module ctm_front #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctm_pkg::ctm_cfg_t     cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           in_sample_value,
  input  wire logic [31:0]           in_time_ms,
  input  wire logic                  q_full,
  output logic                       push,
  output ctm_pkg::ctm_flags_t        flags,
  output logic [TIME_BITS-1:0]       span
);

  logic                          was_above_r;
  logic [ctm_pkg::CNT_BITS-1:0]  pulse_count_r;
  logic [ctm_pkg::CNT_BITS-1:0]  tick_count_r;
  logic [TIME_BITS-1:0]          first_stamp_r;

  logic [TIME_BITS+31:0]         stamp_wide;
  logic [TIME_BITS-1:0]          stamp;
  logic [TIME_BITS-1:0]          first;
  logic                          above;
  logic                          rise;
  logic [ctm_pkg::CNT_BITS:0]    pc_inc;
  logic [ctm_pkg::CNT_BITS:0]    tc_inc;
  logic [ctm_pkg::CNT_BITS-1:0]  ratio;
  logic                          grp_done;
  logic                          tick;

  // stamp wraps modulo 2^TIME_BITS
  assign stamp_wide = {{TIME_BITS{1'b0}}, in_time_ms};
  assign stamp      = stamp_wide[TIME_BITS-1:0];

  always_comb begin
    in_stall = q_full;
    push     = in_valid && !q_full;
    above    = in_sample_value > cfg.level_threshold;
    rise     = above && !was_above_r;
    first    = (pulse_count_r == '0) ? stamp : first_stamp_r;
    span     = stamp - first;
    pc_inc   = {1'b0, pulse_count_r} + 1'b1;
    grp_done = pc_inc >= {1'b0, cfg.pulses_per_beat};
    ratio    = (cfg.divide_ratio == '0) ? 7'd1 : cfg.divide_ratio;
    tc_inc   = {1'b0, tick_count_r} + 1'b1;
    tick     = tc_inc >= {1'b0, ratio};
    flags.edge_seen    = rise;
    flags.divided_tick = rise && tick;
    flags.group_done   = rise && grp_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_above_r   <= 1'b0;
      pulse_count_r <= '0;
      tick_count_r  <= '0;
      first_stamp_r <= '0;
    end else if (push) begin
      was_above_r <= above;
      if (rise) begin
        first_stamp_r <= first;
        pulse_count_r <= grp_done ? '0 : pc_inc[ctm_pkg::CNT_BITS-1:0];
        tick_count_r  <= tick ? '0 : tc_inc[ctm_pkg::CNT_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ctm_queue.sv =====
// Small FIFO between the front and back ends.
// Register-based storage, combinational read of the head entry.
// No package dependency.
`default_nettype none

module ctm_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  nonempty,
  output logic                  full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;

  assign dout     = mem_r[rd_ptr_r];
  assign nonempty = count_r != '0;
  assign full     = count_r == CNT_BITS'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      unique if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end else begin
        count_r <= count_r;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> count_r == CNT_BITS'(DEPTH) || !$past(push))
    else $error("queue written while full");
`endif

endmodule

`default_nettype wire

// ===== src/ctm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Shared by the per-group tempo and the average; depends on ctm_pkg.
`default_nettype none

module ctm_div #(
  parameter int DEN_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ctm_pkg::NUM_BITS-1:0]  num,
  input  wire logic [DEN_BITS-1:0]           den,
  output logic                               done,
  output logic [ctm_pkg::NUM_BITS-1:0]       quot
);

  localparam int STEP_BITS = $clog2(ctm_pkg::NUM_BITS + 1);

  logic [DEN_BITS-1:0]           rem_r;
  logic [DEN_BITS-1:0]           den_r;
  logic [ctm_pkg::NUM_BITS-1:0]  quo_r;
  logic [STEP_BITS-1:0]          step_r;
  logic                          busy_r;
  logic                          done_r;

  logic [DEN_BITS:0]             trial;
  logic                          fits;

  assign trial = {rem_r, quo_r[ctm_pkg::NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(ctm_pkg::NUM_BITS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits DEN_BITS
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_BITS'(trial - {1'b0, den_r}) : trial[DEN_BITS-1:0];
      quo_r <= {quo_r[ctm_pkg::NUM_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== src/ctm_back.sv =====
// Back end: per-group tempo, running sum, average and the output register.
// Uses ctm_div for both divisions; depends on ctm_pkg.
`default_nettype none

module ctm_back #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ctm_pkg::ctm_cfg_t              cfg,
  input  wire logic                           q_valid,
  input  wire ctm_pkg::ctm_flags_t            q_flags,
  input  wire logic [TIME_BITS-1:0]           q_span,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_edge_seen,
  output logic                                out_divided_tick,
  output logic                                out_bpm_valid,
  output logic [ctm_pkg::CENTI_BITS-1:0]      out_average_bpm_centi,
  output logic                                out_span_error
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TSTART = 3'd1;
  localparam logic [2:0] S_TWAIT  = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_ASTART = 3'd4;
  localparam logic [2:0] S_AWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]                      state_r;
  logic [2:0]                      state_nxt;
  ctm_pkg::ctm_flags_t             flags_r;
  logic [ctm_pkg::NUM_BITS-1:0]    num_r;
  logic [TIME_BITS-1:0]            den_r;
  logic [ctm_pkg::CENTI_BITS-1:0]  tempo_r;
  logic [ctm_pkg::CENTI_BITS-1:0]  avg_r;
  logic                            err_r;
  logic                            bpmv_r;
  logic [ctm_pkg::SUM_BITS-1:0]    bpm_sum_r;
  logic [ctm_pkg::GRP_BITS-1:0]    group_count_r;

  logic                            out_valid_r;
  logic                            out_edge_r;
  logic                            out_tick_r;
  logic                            out_bpmv_r;
  logic [ctm_pkg::CENTI_BITS-1:0]  out_avg_r;
  logic                            out_err_r;

  logic                            out_free;
  logic                            out_load;
  logic                            direct;
  logic                            span_zero;
  logic [ctm_pkg::GRP_BITS-1:0]    groups;
  logic [ctm_pkg::SUM_BITS-1:0]    sum_nxt;
  logic [ctm_pkg::GRP_BITS-1:0]    gc_inc;
  logic                            avg_now;
  logic [ctm_pkg::NUM_BITS-1:0]    prod;
  logic                            div_start;
  logic                            div_done;
  logic [ctm_pkg::NUM_BITS-1:0]    div_quot;
  logic [ctm_pkg::SUM_BITS-1:0]    q_hi;
  logic [ctm_pkg::CENTI_BITS-1:0]  tempo_div;

  ctm_div #(.DEN_BITS(TIME_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    pop       = (state_r == S_IDLE) && q_valid && out_free;
    direct    = pop && !q_flags.group_done;
    out_load  = direct || ((state_r == S_EMIT) && out_free);
    span_zero = q_span == '0;
    div_start = (state_r == S_TSTART) || (state_r == S_ASTART);
    prod      = ctm_pkg::NUM_BITS'(ctm_pkg::CENTI_MINUTE_MS)
              * ctm_pkg::NUM_BITS'(cfg.correction_q16);

    priority if (cfg.groups_to_average == '0) begin
      groups = 5'd1;
    end else if (cfg.groups_to_average > ctm_pkg::GROUPS_MAX) begin
      groups = ctm_pkg::GROUPS_MAX;
    end else begin
      groups = cfg.groups_to_average;
    end

    sum_nxt = bpm_sum_r + ctm_pkg::SUM_BITS'(tempo_r);
    gc_inc  = group_count_r + 1'b1;
    avg_now = gc_inc >= groups;

    // drop the Q16 fraction, then saturate
    q_hi      = div_quot[ctm_pkg::NUM_BITS-1:16];
    tempo_div = (q_hi > ctm_pkg::SUM_BITS'(ctm_pkg::BPM_MAX)) ? ctm_pkg::BPM_MAX
              : q_hi[ctm_pkg::CENTI_BITS-1:0];

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop && q_flags.group_done) begin
          state_nxt = span_zero ? S_SUM : S_TSTART;
        end
      end
      S_TSTART: state_nxt = S_TWAIT;
      S_TWAIT:  state_nxt = div_done ? S_SUM : S_TWAIT;
      S_SUM:    state_nxt = avg_now ? S_ASTART : S_EMIT;
      S_ASTART: state_nxt = S_AWAIT;
      S_AWAIT:  state_nxt = div_done ? S_EMIT : S_AWAIT;
      S_EMIT:   state_nxt = out_free ? S_IDLE : S_EMIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bpm_sum_r     <= '0;
      group_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SUM) begin
        if (avg_now) begin
          bpm_sum_r     <= '0;
          group_count_r <= '0;
        end else begin
          bpm_sum_r     <= sum_nxt;
          group_count_r <= gc_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      flags_r <= q_flags;
      den_r   <= q_span;
      num_r   <= prod;
      err_r   <= span_zero;
      tempo_r <= ctm_pkg::BPM_MAX;
      bpmv_r  <= 1'b0;
      avg_r   <= '0;
    end
    if ((state_r == S_TWAIT) && div_done) begin
      tempo_r <= tempo_div;
    end
    if ((state_r == S_SUM) && avg_now) begin
      num_r  <= ctm_pkg::NUM_BITS'(sum_nxt);
      den_r  <= TIME_BITS'(groups);
      bpmv_r <= 1'b1;
    end
    if ((state_r == S_AWAIT) && div_done) begin
      avg_r <= div_quot[ctm_pkg::CENTI_BITS-1:0];
    end
    if (direct) begin
      out_edge_r <= q_flags.edge_seen;
      out_tick_r <= q_flags.divided_tick;
      out_bpmv_r <= 1'b0;
      out_avg_r  <= '0;
      out_err_r  <= 1'b0;
    end else if (out_load) begin
      out_edge_r <= flags_r.edge_seen;
      out_tick_r <= flags_r.divided_tick;
      out_bpmv_r <= bpmv_r;
      out_avg_r  <= avg_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_edge_seen         = out_edge_r;
  assign out_divided_tick      = out_tick_r;
  assign out_bpm_valid         = out_bpmv_r;
  assign out_average_bpm_centi = out_avg_r;
  assign out_span_error        = out_err_r;

`ifndef NO_ASSERTIONS
  a_result_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_bpmv_r || out_err_r) |-> out_edge_r)
    else $error("tempo result without a rising edge");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_TWAIT || state_r == S_AWAIT)
    else $error("divider finished outside a wait state");

  a_group_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM && avg_now |=> group_count_r == '0 && bpm_sum_r == '0)
    else $error("averaging did not clear the running sum");
`endif

endmodule

`default_nettype wire

// ===== src/clock_pulse_tempo_meter.sv =====
// Top level of the clock pulse tempo meter: APB configuration registers,
// front end, queue and back end. Depends on ctm_pkg, ctm_front, ctm_queue,
// ctm_back and ctm_div.
`default_nettype none

// Takes one sample per transaction and returns exactly one result transaction
// for it, in order. A sample that does not complete a pulse group passes front,
// queue and back with no divider pass, so such samples stream at one per cycle
// while the back end is idle and the output is not stalled. A sample that
// completes a group with a nonzero span runs the serial divider (one quotient
// bit per cycle) in the back end; when it also completes the averaging window
// a second divider pass follows. The queue (QUEUE_DEPTH entries) lets samples
// keep arriving while the divider works. Registers are to be written over APB
// only while no transaction is in flight; the block itself does not enforce it.
module clock_pulse_tempo_meter #(
  parameter int TIME_BITS   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [15:0]                       in_sample_value,
  input  wire logic [31:0]                       in_time_ms,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_edge_seen,
  output logic                                   out_divided_tick,
  output logic                                   out_bpm_valid,
  output logic [ctm_pkg::CENTI_BITS-1:0]         out_average_bpm_centi,
  output logic                                   out_span_error,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ctm_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [ctm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ctm_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready
);

  localparam int Q_WIDTH = ctm_pkg::FLAG_BITS + TIME_BITS;

  ctm_pkg::ctm_cfg_t      cfg_r;
  logic [2:0]             reg_idx;
  logic                   wr_en;

  logic                   q_full;
  logic                   q_nonempty;
  logic                   push;
  logic                   pop;
  ctm_pkg::ctm_flags_t    f_flags;
  logic [TIME_BITS-1:0]   f_span;
  logic [Q_WIDTH-1:0]     q_dout;
  ctm_pkg::ctm_flags_t    q_flags;
  logic [TIME_BITS-1:0]   q_span;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_threshold   <= ctm_pkg::RST_LEVEL_THRESHOLD;
      cfg_r.pulses_per_beat   <= ctm_pkg::RST_PULSES_PER_BEAT;
      cfg_r.groups_to_average <= ctm_pkg::RST_GROUPS_TO_AVERAGE;
      cfg_r.correction_q16    <= ctm_pkg::RST_CORRECTION_Q16;
      cfg_r.divide_ratio      <= ctm_pkg::RST_DIVIDE_RATIO;
    end else if (wr_en) begin
      unique case (reg_idx)
        ctm_pkg::REG_LEVEL_THRESHOLD:   cfg_r.level_threshold   <= pwdata[15:0];
        ctm_pkg::REG_PULSES_PER_BEAT:   cfg_r.pulses_per_beat   <= pwdata[6:0];
        ctm_pkg::REG_GROUPS_TO_AVERAGE: cfg_r.groups_to_average <= pwdata[4:0];
        ctm_pkg::REG_CORRECTION_Q16:    cfg_r.correction_q16    <= pwdata[16:0];
        ctm_pkg::REG_DIVIDE_RATIO:      cfg_r.divide_ratio      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ctm_pkg::REG_LEVEL_THRESHOLD:   prdata = 32'(cfg_r.level_threshold);
      ctm_pkg::REG_PULSES_PER_BEAT:   prdata = 32'(cfg_r.pulses_per_beat);
      ctm_pkg::REG_GROUPS_TO_AVERAGE: prdata = 32'(cfg_r.groups_to_average);
      ctm_pkg::REG_CORRECTION_Q16:    prdata = 32'(cfg_r.correction_q16);
      ctm_pkg::REG_DIVIDE_RATIO:      prdata = 32'(cfg_r.divide_ratio);
      default:                        prdata = '0;
    endcase
  end

  ctm_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_time_ms      (in_time_ms),
    .q_full          (q_full),
    .push            (push),
    .flags           (f_flags),
    .span            (f_span)
  );

  ctm_queue #(.WIDTH(Q_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      ({f_flags, f_span}),
    .pop      (pop),
    .dout     (q_dout),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  assign q_flags = q_dout[Q_WIDTH-1:TIME_BITS];
  assign q_span  = q_dout[TIME_BITS-1:0];

  ctm_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (q_nonempty),
    .q_flags               (q_flags),
    .q_span                (q_span),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_edge_seen         (out_edge_seen),
    .out_divided_tick      (out_divided_tick),
    .out_bpm_valid         (out_bpm_valid),
    .out_average_bpm_centi (out_average_bpm_centi),
    .out_span_error        (out_span_error)
  );

endmodule

`default_nettype wire
